// File: hdl/bils_pkg.sv
`timescale 1ns / 1ps

package bils_pkg;

    localparam int WORD_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int WORD_BYTES = WORD_W / BYTE_W;

    // Parser phases; codes without a member behave as finished.
    typedef enum logic [2:0] {
        PH_FINISHED = 3'd0,
        PH_LENGTH   = 3'd1,
        PH_ADDRESS  = 3'd2,
        PH_DATA     = 3'd3,
        PH_ENTRY    = 3'd4,
        PH_CHECK    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_BAD   = 2'd2
    } kind_t;

    // One registered input beat.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              start;
    } in_beat_t;

    // One result item.
    typedef struct packed {
        kind_t             kind;
        logic [WORD_W-1:0] target_address;
        logic [WORD_W-1:0] payload;
    } result_t;

endpackage

// File: hdl/bils_in_stage.sv
`timescale 1ns / 1ps

module bils_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    output logic               s_ready,
    input  bils_pkg::in_beat_t s_beat,
    input  logic               take,
    output logic               beat_valid,
    output bils_pkg::in_beat_t beat
);

    logic               vld_reg;
    logic               vld_next;
    bils_pkg::in_beat_t beat_reg;

    // The register can be refilled in the same cycle that the parser drains it.
    assign s_ready  = !vld_reg || take;
    assign vld_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            beat_reg <= s_beat;
        end
    end

    assign beat_valid = vld_reg;
    assign beat       = beat_reg;

endmodule

// File: hdl/bils_parser.sv
`timescale 1ns / 1ps

module bils_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  bils_pkg::in_beat_t beat,
    output logic               res_valid,
    output bils_pkg::result_t  res
);

    bils_pkg::phase_t               phase_reg, phase_next;
    logic [bils_pkg::WORD_W-1:0]    sum_reg, sum_next;
    logic [bils_pkg::WORD_W-1:0]    remaining_reg, remaining_next;
    logic [bils_pkg::WORD_W-1:0]    waddr_reg, waddr_next;
    logic [bils_pkg::WORD_W-1:0]    entry_reg, entry_next;

    always_comb
    begin
        phase_next         = phase_reg;
        sum_next           = sum_reg;
        remaining_next     = remaining_reg;
        waddr_next         = waddr_reg;
        entry_next         = entry_reg;
        res_valid          = 1'b0;
        res.kind           = bils_pkg::KIND_WRITE;
        res.target_address = waddr_reg;
        res.payload        = beat.word;

        if (take)
        begin
            if (beat.start)
            begin
                // A header word restarts the parse from any phase.
                sum_next       = '0;
                remaining_next = '0;
                phase_next     = bils_pkg::PH_LENGTH;
            end
            else
            begin
                case (phase_reg)
                    bils_pkg::PH_LENGTH:
                    begin
                        remaining_next = beat.word;
                        phase_next     = (beat.word != '0) ? bils_pkg::PH_ADDRESS
                                                           : bils_pkg::PH_ENTRY;
                    end
                    bils_pkg::PH_ADDRESS:
                    begin
                        waddr_next = beat.word;
                        phase_next = bils_pkg::PH_DATA;
                    end
                    bils_pkg::PH_DATA:
                    begin
                        res_valid      = 1'b1;
                        sum_next       = sum_reg + beat.word;
                        waddr_next     = waddr_reg
                                       + bils_pkg::WORD_W'(bils_pkg::WORD_BYTES);
                        remaining_next = remaining_reg - bils_pkg::WORD_W'(1);
                        if (remaining_reg == bils_pkg::WORD_W'(1))
                        begin
                            phase_next = bils_pkg::PH_LENGTH;
                        end
                    end
                    bils_pkg::PH_ENTRY:
                    begin
                        entry_next = beat.word;
                        phase_next = bils_pkg::PH_CHECK;
                    end
                    bils_pkg::PH_CHECK:
                    begin
                        res_valid          = 1'b1;
                        res.kind           = (sum_reg == beat.word) ? bils_pkg::KIND_GOOD
                                                                    : bils_pkg::KIND_BAD;
                        res.target_address = entry_reg;
                        res.payload        = sum_reg;
                        phase_next         = bils_pkg::PH_FINISHED;
                    end
                    default:
                    begin
                        phase_next = bils_pkg::PH_FINISHED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= bils_pkg::PH_FINISHED;
            sum_reg       <= '0;
            remaining_reg <= '0;
            waddr_reg     <= '0;
            entry_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            remaining_reg <= remaining_next;
            waddr_reg     <= waddr_next;
            entry_reg     <= entry_next;
        end
    end

endmodule

// File: hdl/bils_out_stage.sv
`timescale 1ns / 1ps

module bils_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  bils_pkg::result_t res,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output bils_pkg::result_t m_res
);

    logic              vld_reg;
    logic              vld_next;
    bils_pkg::result_t res_reg;

    // Room whenever the register is empty or its beat leaves this cycle.
    assign room     = !vld_reg || m_ready;
    assign vld_next = room ? res_valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_valid = vld_reg;
    assign m_res   = res_reg;

endmodule

// File: hdl/boot_image_section_loader.sv
`timescale 1ns / 1ps

// Boot image section loader. Words of a boot image arrive one beat at a time on the
// slave stream; a beat with the start flag in tuser is the header and restarts the
// parse and the checksum. Each section (length in words, load address, data words)
// produces one RAM-write beat per data word on the master stream, at the load address
// plus four bytes per word, and every data word goes into a wrapping 32-bit sum. A
// zero length opens the terminator: an entry address, then the expected checksum,
// which yields one completion beat (kind good or mismatch, entry address, computed
// sum). Other beats produce nothing, and words after the terminator are ignored until
// the next start flag. The block accepts one word every clock cycle while the master
// side is not stalling; each word is held in the input register, the parser step on
// it is combinational, and its result beat is captured in the result register, from
// which it is presented on the master side. Backpressure on the master side stalls
// the input only while the result register is full and not being taken.
module boot_image_section_loader
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] image_word
    input  logic        s_axis_tuser,   // [0] start_of_image
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] target_address, [63:32] payload
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);

    bils_pkg::in_beat_t s_beat;
    bils_pkg::in_beat_t beat;
    bils_pkg::result_t  res;
    bils_pkg::result_t  m_res;
    logic               beat_valid;
    logic               room;
    logic               take;
    logic               res_valid;

    assign s_beat.word  = s_axis_tdata;
    assign s_beat.start = s_axis_tuser;

    // The parser steps on a buffered word only when the result register can take it.
    assign take = beat_valid && room;

    bils_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_beat     (s_beat),
        .take       (take),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    bils_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .beat      (beat),
        .res_valid (res_valid),
        .res       (res)
    );

    bils_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .room      (room),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_res     (m_res)
    );

    assign m_axis_tdata = {m_res.payload, m_res.target_address};
    assign m_axis_tuser = m_res.kind;

endmodule

// File: hdl/bils_checker.sv
`timescale 1ns / 1ps

module bils_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result beat holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // Only the three defined result kinds ever leave the block.
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == bils_pkg::KIND_WRITE
                           || m_axis_tuser == bils_pkg::KIND_GOOD
                           || m_axis_tuser == bils_pkg::KIND_BAD))
        else $error("undefined result kind");

    // The input side is held off only by a full, stalled result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // With the output free, the block takes a word every cycle.
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready while output is empty");

endmodule

bind boot_image_section_loader bils_checker u_bils_checker (.*);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import bils_pkg::*;

    // Length of the receiver hold-off that forces the block to fill up and stall.
    localparam int HOLD_CYCLES  = 300;
    // Image words to send in the random part.
    localparam int RANDOM_WORDS = 500;
    // Cycles to wait after the last result before the final check.
    localparam int TAIL_CYCLES  = 8;
    // Hard limit on the run, far above the slowest correct run.
    localparam int RUN_LIMIT_NS = 2_000_000;
    // Length of the section sent while the receiver is held off.
    localparam int FLOOD_WORDS  = 40;

    // Tracks the parse of the image as the block should see it, keeps the result
    // beats it must produce in order, and checks each result beat against them.
    class image_tracker;
        phase_t      phase;
        logic [31:0] sum;
        logic [31:0] left;
        logic [31:0] wr_addr;
        logic [31:0] entry;
        result_t     due_beats[$];
        int          faults;
        int          writes_seen;
        int          good_seen;
        int          bad_seen;

        function new();
            phase       = PH_FINISHED;
            sum         = '0;
            left        = '0;
            wr_addr     = '0;
            entry       = '0;
            faults      = 0;
            writes_seen = 0;
            good_seen   = 0;
            bad_seen    = 0;
        endfunction

        function void report(string msg);
            faults++;
            if (faults <= 10)
            begin
                $display("MISMATCH: %s", msg);
            end
        endfunction

        // Advances the parse by one accepted word and queues the beat it causes.
        function void take_word(logic [31:0] w, logic st);
            result_t r;
            if (st)
            begin
                sum   = '0;
                left  = '0;
                phase = PH_LENGTH;
                return;
            end
            case (phase)
                PH_LENGTH:
                begin
                    left  = w;
                    phase = (w != 0) ? PH_ADDRESS : PH_ENTRY;
                end
                PH_ADDRESS:
                begin
                    wr_addr = w;
                    phase   = PH_DATA;
                end
                PH_DATA:
                begin
                    r.kind           = KIND_WRITE;
                    r.target_address = wr_addr;
                    r.payload        = w;
                    due_beats.push_back(r);
                    sum     = sum + w;
                    wr_addr = wr_addr + WORD_BYTES;
                    left    = left - 1;
                    if (left == 0)
                    begin
                        phase = PH_LENGTH;
                    end
                end
                PH_ENTRY:
                begin
                    entry = w;
                    phase = PH_CHECK;
                end
                PH_CHECK:
                begin
                    r.kind           = (sum == w) ? KIND_GOOD : KIND_BAD;
                    r.target_address = entry;
                    r.payload        = sum;
                    due_beats.push_back(r);
                    phase = PH_FINISHED;
                end
                default:
                begin
                    phase = PH_FINISHED;
                end
            endcase
        endfunction

        function void match_beat(result_t got);
            result_t want;
            if (due_beats.size() == 0)
            begin
                report($sformatf("unexpected beat kind %0d addr %h data %h",
                                 got.kind, got.target_address, got.payload));
                return;
            end
            want = due_beats.pop_front();
            if (got.kind !== want.kind)
            begin
                report($sformatf("kind: expected %0d, got %0d", want.kind, got.kind));
            end
            if (got.target_address !== want.target_address)
            begin
                report($sformatf("target_address: expected %h, got %h",
                                 want.target_address, got.target_address));
            end
            if (got.payload !== want.payload)
            begin
                report($sformatf("payload: expected %h, got %h", want.payload, got.payload));
            end
            case (want.kind)
                KIND_WRITE: writes_seen++;
                KIND_GOOD:  good_seen++;
                default:    bad_seen++;
            endcase
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] image_word
    logic        s_axis_tuser  = 1'b0; // [0] start_of_image
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // [31:0] target_address, [63:32] payload
    logic [1:0]  m_axis_tuser;         // [1:0] kind

    // Percent chance per cycle that the sender or the receiver idles.
    int send_idle_pct = 29;
    int recv_idle_pct = 72;

    // Raised for one cycle by the stimulus to start the long receiver hold-off.
    logic hold_wanted = 1'b0;
    int   hold_left   = 0;

    int image_words = 0;

    image_tracker tracker = new();

    boot_image_section_loader uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // Receiver side. The long hold-off is counted here so that the sender keeps
    // offering words while the block fills up behind the stalled output.
    always @(posedge clk)
    begin
        if (hold_wanted && hold_left == 0)
        begin
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watches both handshakes. A result beat always belongs to a word accepted at
    // an earlier edge, so checking before noting the new word is safe.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind           = kind_t'(m_axis_tuser);
                got.target_address = m_axis_tdata[31:0];
                got.payload        = m_axis_tdata[63:32];
                tracker.match_beat(got);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                tracker.take_word(s_axis_tdata, s_axis_tuser);
            end
        end
    end

    // Offers one word after a random idle gap and returns at the edge where the
    // block takes it. The valid line is only lowered when a gap is inserted, so a
    // back-to-back beat never sees valid dropped and raised in the same step.
    task automatic send_word(input logic [31:0] w, input logic st);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= st;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Stops offering words and waits until every queued result beat has arrived.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.due_beats.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Builds one image with random content. Most images are well formed, with a
    // correct checksum most of the time; a few are cut short, and a few carry a
    // huge section length so that the next start flag lands in the data phase.
    task automatic send_random_image();
        logic [31:0] body[$];
        logic [31:0] sum;
        logic [31:0] len;
        logic [31:0] w;
        int          nsec;
        int          cut;
        bit          broken;
        sum    = '0;
        broken = 1'b0;
        nsec   = $urandom_range(0, 3);
        for (int s = 0; s < nsec && !broken; s++)
        begin
            if ($urandom_range(99) < 4)
            begin
                len = $urandom | 32'h0000_1000;
                body.push_back(len);
                body.push_back($urandom);
                repeat ($urandom_range(1, 6)) body.push_back($urandom);
                broken = 1'b1;
            end
            else
            begin
                len = $urandom_range(1, 6);
                body.push_back(len);
                body.push_back($urandom);
                repeat (len)
                begin
                    w   = $urandom;
                    sum = sum + w;
                    body.push_back(w);
                end
            end
        end
        if (!broken)
        begin
            body.push_back(32'h0);
            body.push_back($urandom);
            if ($urandom_range(99) < 80)
            begin
                body.push_back(sum);
            end
            else
            begin
                body.push_back(sum ^ (32'h1 << $urandom_range(31)));
            end
            if ($urandom_range(99) < 10)
            begin
                cut = $urandom_range(0, body.size() - 1);
                while (body.size() > cut)
                begin
                    void'(body.pop_back());
                end
            end
        end
        send_word($urandom, 1'b1);
        foreach (body[i])
        begin
            send_word(body[i], 1'b0);
        end
        image_words += body.size() + 1;
        // Stray words between images; after a complete image they are ignored.
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(1, 3)) send_word($urandom, 1'b0);
        end
    endtask

    initial
    begin
        logic [31:0] flood_sum;
        logic [31:0] w;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A word before any start flag must be ignored.
        send_word(32'hFFFF_FFFF, 1'b0);

        // Good image: extreme data, a write address that wraps past the top of
        // the address space, and a sum that wraps.
        send_word(32'h0000_0000, 1'b1);
        send_word(32'h0000_0002, 1'b0);
        send_word(32'hFFFF_FFFC, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b0);
        // After completion words are ignored until the next start flag.
        send_word(32'h1234_5678, 1'b0);

        // Checksum mismatch.
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);

        // Restart in the middle of a section clears the sum; the restart is
        // followed by an empty image whose checksum is zero.
        send_word(32'h0000_0000, 1'b1);
        send_word(32'h0000_0003, 1'b0);
        send_word(32'h0000_0100, 1'b0);
        send_word(32'h0000_0005, 1'b0);
        send_word(32'hA5A5_A5A5, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_C0DE, 1'b0);
        send_word(32'h0000_0000, 1'b0);

        // Restarts while the entry address and the checksum are awaited.
        send_word(32'h0000_0000, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0004, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0008, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0008, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        drain();

        // Hold the receiver off for a long stretch while a long section streams in,
        // so that the block fills up and stalls its input.
        hold_wanted <= 1'b1;
        @(posedge clk);
        hold_wanted <= 1'b0;
        flood_sum = '0;
        send_word($urandom, 1'b1);
        send_word(FLOOD_WORDS, 1'b0);
        send_word($urandom, 1'b0);
        repeat (FLOOD_WORDS)
        begin
            w         = $urandom;
            flood_sum = flood_sum + w;
            send_word(w, 1'b0);
        end
        send_word(32'h0, 1'b0);
        send_word($urandom, 1'b0);
        send_word(flood_sum, 1'b0);
        drain();

        // Random part in three stretches of idling: sender light and receiver
        // heavy, then the other way round, then no idling at all.
        while (image_words < RANDOM_WORDS)
        begin
            if (image_words < RANDOM_WORDS / 3)
            begin
                send_idle_pct = 29;
                recv_idle_pct = 72;
            end
            else if (image_words < 2 * RANDOM_WORDS / 3)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_random_image();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.due_beats.size() != 0)
        begin
            tracker.report($sformatf("%0d result beats never arrived",
                                     tracker.due_beats.size()));
        end
        $display("Sent %0d random image words plus directed images and a stalled flood.",
                 image_words);
        $display("Checked %0d RAM writes, %0d good and %0d mismatched completions.",
                 tracker.writes_seen, tracker.good_seen, tracker.bad_seen);
        if (tracker.faults == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d result beats outstanding.", tracker.due_beats.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
hdl/bils_pkg.sv
hdl/bils_in_stage.sv
hdl/bils_parser.sv
hdl/bils_out_stage.sv
hdl/boot_image_section_loader.sv
hdl/bils_checker.sv
tb/sv/tb_top.sv
